// File: rtl/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked on the same edge, idle during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked implication checked on the following edge, idle during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcc_pkg.sv
package pcc_pkg;

	localparam int CRC_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int FILL_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [FILL_W-1:0] TAIL_BYTES   = 3'd4;
	localparam logic [CRC_W-1:0]  POLY_RESET   = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0]  MAGIC_RESET  = 32'd9876;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLY      = 2'd0,
		CFG_MAGIC_EN  = 2'd1,
		CFG_MAGIC_VAL = 2'd2
	} cfg_idx_t;

	// Reflected CRC over one byte, one shift per bit
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] data,
		input logic [CRC_W-1:0]  poly
	);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/packet_crc32_checker.sv
// Packet CRC-32 checker.
// Input channel: in_valid / in_stall carry one packet byte per beat
// (data_byte) with last_byte set on the final byte of the packet.
// Output channel: out_valid / out_stall carry one result per packet:
// crc_good, computed_crc, received_crc and too_short.
// The CRC (reflected, zero start, no final inversion) covers every byte
// except the trailing four, which are read little-endian as the received CRC.
// Throughput: one byte per cycle unless a final byte waits behind a stalled result;
// the byte CRC is an unrolled eight-step shift of the oldest window byte into crc_q.
// A final byte passes from the input register to the result register.
// The user writes configuration (cfg_wr_en, cfg_index, cfg_data) only while idle;
// the block does not enforce it. Index 0 polynomial, 1 magic accept enable, 2 magic value; others ignored.
// Reset clears both channels, the packet state, and loads the polynomial
// 0xEDB88320, bypass disabled and magic value 9876.
// When the receiver stalls, the result holds; non-final bytes keep flowing,
// and only a final byte waits in the input register, raising in_stall.
module packet_crc32_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcc_pkg::CRC_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pcc_pkg::BYTE_W-1:0]       data_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             crc_good,
	output logic [pcc_pkg::CRC_W-1:0]        computed_crc,
	output logic [pcc_pkg::CRC_W-1:0]        received_crc,
	output logic                             too_short
);

	// Configuration
	logic [pcc_pkg::CRC_W-1:0] poly_q;
	logic                      magic_en_q;
	logic [pcc_pkg::CRC_W-1:0] magic_val_q;

	// Input stage
	logic                       valid_s1;
	logic                       last_s1;
	logic [pcc_pkg::BYTE_W-1:0] byte_s1;

	// Packet state
	logic [pcc_pkg::CRC_W-1:0]  crc_q;
	logic [pcc_pkg::CRC_W-1:0]  win_q;
	logic [pcc_pkg::FILL_W-1:0] fill_q;

	// Result register
	logic                      out_valid_q;
	logic                      good_q;
	logic [pcc_pkg::CRC_W-1:0] comp_q;
	logic [pcc_pkg::CRC_W-1:0] recv_q;
	logic                      short_q;

	logic                       adv_s1;
	logic                       take_in;
	logic                       full;
	logic                       short_pkt;
	logic [pcc_pkg::CRC_W-1:0]  crc_next;
	logic [pcc_pkg::CRC_W-1:0]  win_next;
	logic [pcc_pkg::FILL_W-1:0] fill_next;

	// Hold a final byte only while a finished result is stalled
	assign adv_s1   = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// Oldest window byte enters the CRC once the window is full
	assign full      = (fill_q == pcc_pkg::TAIL_BYTES);
	assign crc_next  = full ? pcc_pkg::crc_byte(crc_q, win_q[pcc_pkg::BYTE_W-1:0], poly_q)
				: crc_q;
	assign win_next  = {byte_s1, win_q[pcc_pkg::CRC_W-1:pcc_pkg::BYTE_W]};
	assign fill_next = full ? fill_q : fill_q + 3'd1;
	assign short_pkt = (fill_next != pcc_pkg::TAIL_BYTES);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q      <= pcc_pkg::POLY_RESET;
			magic_en_q  <= 1'b0;
			magic_val_q <= pcc_pkg::MAGIC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pcc_pkg::CFG_POLY:      poly_q      <= cfg_data;
				pcc_pkg::CFG_MAGIC_EN:  magic_en_q  <= cfg_data[0];
				pcc_pkg::CFG_MAGIC_VAL: magic_val_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: load a beat, drop the stage once it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
			last_s1  <= last_byte;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= data_byte;
		end
	end

	// Packet state: advance on each byte, clear after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			win_q  <= '0;
			fill_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				crc_q  <= '0;
				win_q  <= '0;
				fill_q <= '0;
			end else begin
				crc_q  <= crc_next;
				win_q  <= win_next;
				fill_q <= fill_next;
			end
		end
	end

	// Result valid: set on a final byte, clear when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			short_q <= short_pkt;
			if (short_pkt) begin
				good_q <= 1'b0;
				comp_q <= '0;
				recv_q <= '0;
			end else begin
				good_q <= (crc_next == win_next) ||
					  (magic_en_q && (win_next == magic_val_q));
				comp_q <= crc_next;
				recv_q <= win_next;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign crc_good     = good_q;
	assign computed_crc = comp_q;
	assign received_crc = recv_q;
	assign too_short    = short_q;

endmodule

// File: rtl/pcc_checker.sv
`include "assert_macros.svh"

module pcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          crc_good,
	input logic [pcc_pkg::CRC_W-1:0]     computed_crc,
	input logic [pcc_pkg::CRC_W-1:0]     received_crc,
	input logic                          too_short
);

	// Input backs up only behind a stalled result
	`ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall, "in_stall without stalled result")

	// A short packet never passes, bypass or not
	`ASSERT_SAME(a_short_bad, out_valid && too_short, !crc_good, "short packet flagged good")

	// A short packet reports zero CRC fields
	`ASSERT_SAME(a_short_zero, out_valid && too_short, computed_crc == '0 && received_crc == '0, "short packet CRC fields not zero")

	// Matching CRCs on a full packet always pass
	`ASSERT_SAME(a_match_good, out_valid && !too_short && computed_crc == received_crc, crc_good, "matching CRC not flagged good")

	// A stalled result beat holds
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(computed_crc) && $stable(received_crc) && $stable(crc_good), "stalled result changed")

endmodule

bind packet_crc32_checker pcc_checker u_pcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.crc_good     (crc_good),
	.computed_crc (computed_crc),
	.received_crc (received_crc),
	.too_short    (too_short)
);
